// File: rtl/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared codes and field widths of the LRU cache tag model.
// ----------------------------------------------------------------------------
`default_nettype none

package sacl_pkg;

  localparam int FUNC_W    = 2;
  localparam int ADDR_W    = 64;
  localparam int OUTC_W    = 2;
  localparam int WAY_OUT_W = 3;
  localparam int CNT_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 6;

  localparam int SB_W   = 3;
  localparam int BB_W   = 6;
  localparam int WAYS_W = 4;

  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STORE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MODIFY = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_INSTR  = 2'd3;

  localparam logic [OUTC_W-1:0] OUTC_HIT   = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_FILL  = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_EVICT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

  localparam logic [SB_W-1:0]   SET_BITS_RST   = 3'd1;
  localparam logic [BB_W-1:0]   BLOCK_BITS_RST = 6'd4;
  localparam logic [WAYS_W-1:0] WAYS_RST       = 4'd1;

endpackage

`default_nettype wire

// File: rtl/set_assoc_cache_lru_model_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_model_unit
// Tag model of a set-associative cache with true LRU replacement.
// ----------------------------------------------------------------------------
//  channel  | ports                                        | handshake
//  request  | start, busy, in_func, in_addr                | start & !busy
//  result   | out_valid, out_outcome .. out_last_of_item   | out_valid, no stall
//  config   | cfg_we, cfg_index, cfg_wdata                 | cfg_we
//
//  A request's result passes the access-stage registers, then the output registers.
//  Load and store make one access each; modify makes two (busy high for one cycle),
//  bound by the single read and write port of the per-set tag memory.
//  Reset clears per-set row-valid flags at once; no clearing pass is needed.
//  Results cannot be stalled; instruction fetches give no result.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_lru_model_unit #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output      logic                            busy,
  input  wire logic [sacl_pkg::FUNC_W-1:0]     in_func,
  input  wire logic [sacl_pkg::ADDR_W-1:0]     in_addr,
  output      logic                            out_valid,
  output      logic [sacl_pkg::OUTC_W-1:0]     out_outcome,
  output      logic [sacl_pkg::WAY_OUT_W-1:0]  out_way_used,
  output      logic [sacl_pkg::CNT_W-1:0]      out_hit_total,
  output      logic [sacl_pkg::CNT_W-1:0]      out_miss_total,
  output      logic [sacl_pkg::CNT_W-1:0]      out_evict_total,
  output      logic                            out_last_of_item,
  input  wire logic                            cfg_we,
  input  wire logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sacl_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
  import sacl_pkg::*;

  localparam int SET_W    = MAX_SET_BITS;
  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int TAG_W    = ADDR_WIDTH - 2;
  localparam int REC_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_W    = REC_W;
  localparam int EW       = $clog2(MAX_WAYS + 1);
  localparam int SH_W     = 7;

  typedef logic [MAX_WAYS-1:0]            valid_row_t;
  typedef logic [MAX_WAYS-1:0][TAG_W-1:0] tag_row_t;
  typedef logic [MAX_WAYS-1:0][REC_W-1:0] rec_row_t;

  // configuration
  logic [SB_W-1:0]   set_bits_r;
  logic [BB_W-1:0]   block_bits_r;
  logic [WAYS_W-1:0] ways_r;

  // request side
  logic              accept;
  logic              rep_r;
  logic [SB_W-1:0]   sb_eff;
  logic [BB_W-1:0]   bb_eff;
  logic [SH_W-1:0]   tag_shift;
  logic [ADDR_W-1:0] addr_m;
  logic [ADDR_W-1:0] set_sh;
  logic [ADDR_W-1:0] tag_sh;
  logic [SET_W-1:0]  set_mask;
  logic [SET_W-1:0]  in_set;
  logic [TAG_W-1:0]  in_tag;
  logic [SET_W-1:0]  rd_addr;

  // access stage
  logic              b_vld_r;
  logic              b_last_r;
  logic [SET_W-1:0]  b_set_r;
  logic [TAG_W-1:0]  b_tag_r;

  // tag memory and row flags
  valid_row_t        mem_valid [NUM_SETS];
  tag_row_t          mem_tag   [NUM_SETS];
  rec_row_t          mem_rec   [NUM_SETS];
  logic [NUM_SETS-1:0] row_init_r;
  valid_row_t        rd_valid_r;
  tag_row_t          rd_tag_r;
  rec_row_t          rd_rec_r;
  logic              rd_init_r;

  // forward of the row written in the cycle before
  logic              fwd_vld_r;
  logic [SET_W-1:0]  fwd_set_r;
  valid_row_t        fwd_valid_r;
  tag_row_t          fwd_tag_r;
  rec_row_t          fwd_rec_r;

  // access logic
  logic [EW-1:0]     ways_eff;
  logic [MAX_WAYS-1:0] in_use;
  valid_row_t        cur_valid;
  tag_row_t          cur_tag;
  rec_row_t          cur_rec;
  logic [MAX_WAYS-1:0] hit_vec;
  logic [MAX_WAYS-1:0] inv_vec;
  logic              hit;
  logic              fill;
  logic [WAY_W-1:0]  hit_way;
  logic [WAY_W-1:0]  inv_way;
  logic [WAY_W-1:0]  lru_way;
  logic [REC_W-1:0]  lru_best;
  logic [WAY_W-1:0]  way;
  logic [REC_W:0]    old_rank;
  valid_row_t        new_valid;
  tag_row_t          new_tag;
  rec_row_t          new_rec;
  logic [OUTC_W-1:0] outcome;
  logic [31:0]       way_ext;

  logic [CNT_W-1:0]  hit_cnt_r;
  logic [CNT_W-1:0]  miss_cnt_r;
  logic [CNT_W-1:0]  evict_cnt_r;
  logic [CNT_W-1:0]  hit_cnt_nxt;
  logic [CNT_W-1:0]  miss_cnt_nxt;
  logic [CNT_W-1:0]  evict_cnt_nxt;

  assign busy   = rep_r;
  assign accept = start && !rep_r;

  always_comb begin
    sb_eff = set_bits_r;
    if (set_bits_r == '0) begin
      sb_eff = SB_W'(1);
    end else if (int'(set_bits_r) > MAX_SET_BITS) begin
      sb_eff = SB_W'(MAX_SET_BITS);
    end
    bb_eff = (block_bits_r == '0) ? BB_W'(1) : block_bits_r;
    tag_shift = SH_W'(sb_eff) + SH_W'(bb_eff);
    for (int k = 0; k < ADDR_W; k++) begin
      addr_m[k] = (k < ADDR_WIDTH) ? in_addr[k] : 1'b0;
    end
    for (int j = 0; j < SET_W; j++) begin
      set_mask[j] = (j < int'(sb_eff));
    end
    set_sh  = addr_m >> bb_eff;
    tag_sh  = (tag_shift >= SH_W'(ADDR_W)) ? '0 : (addr_m >> tag_shift);
    in_set  = set_sh[SET_W-1:0] & set_mask;
    in_tag  = tag_sh[TAG_W-1:0];
    rd_addr = rep_r ? b_set_r : in_set;
  end

  always_comb begin
    ways_eff = EW'(ways_r);
    if (ways_r == '0) begin
      ways_eff = EW'(1);
    end else if (int'(ways_r) > MAX_WAYS) begin
      ways_eff = EW'(MAX_WAYS);
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i] = (EW'(i) < ways_eff);
    end

    if (fwd_vld_r && (fwd_set_r == b_set_r)) begin
      cur_valid = fwd_valid_r;
      cur_tag   = fwd_tag_r;
      cur_rec   = fwd_rec_r;
    end else begin
      cur_valid = rd_init_r ? rd_valid_r : '0;
      cur_tag   = rd_tag_r;
      cur_rec   = rd_init_r ? rd_rec_r : '0;
    end

    for (int i = 0; i < MAX_WAYS; i++) begin
      hit_vec[i] = in_use[i] && cur_valid[i] && (cur_tag[i] == b_tag_r);
      inv_vec[i] = in_use[i] && !cur_valid[i];
    end
    hit  = |hit_vec;
    fill = |inv_vec;

    hit_way = '0;
    inv_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_way = WAY_W'(i);
      end
      if (inv_vec[i]) begin
        inv_way = WAY_W'(i);
      end
    end

    lru_best = '0;
    lru_way  = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (in_use[i] && (cur_rec[i] >= lru_best)) begin
        lru_best = cur_rec[i];
        lru_way  = WAY_W'(i);
      end
    end

    priority if (hit) begin
      way      = hit_way;
      outcome  = OUTC_HIT;
      old_rank = {1'b0, cur_rec[hit_way]};
    end else if (fill) begin
      way      = inv_way;
      outcome  = OUTC_FILL;
      old_rank = (REC_W + 1)'(MAX_WAYS);
    end else begin
      way      = lru_way;
      outcome  = OUTC_EVICT;
      old_rank = {1'b0, cur_rec[lru_way]};
    end

    for (int i = 0; i < MAX_WAYS; i++) begin
      new_tag[i] = (WAY_W'(i) == way) ? b_tag_r : cur_tag[i];
      if (WAY_W'(i) == way) begin
        new_rec[i]   = '0;
        new_valid[i] = 1'b1;
      end else begin
        new_valid[i] = cur_valid[i];
        if (cur_valid[i] && ({1'b0, cur_rec[i]} < old_rank)) begin
          new_rec[i] = cur_rec[i] + REC_W'(1);
        end else begin
          new_rec[i] = cur_rec[i];
        end
      end
    end

    hit_cnt_nxt   = hit_cnt_r;
    miss_cnt_nxt  = miss_cnt_r;
    evict_cnt_nxt = evict_cnt_r;
    if (hit) begin
      if (hit_cnt_r != '1) hit_cnt_nxt = hit_cnt_r + CNT_W'(1);
    end else begin
      if (miss_cnt_r != '1) miss_cnt_nxt = miss_cnt_r + CNT_W'(1);
      if (!fill && (evict_cnt_r != '1)) evict_cnt_nxt = evict_cnt_r + CNT_W'(1);
    end
    way_ext = 32'(way);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= SET_BITS_RST;
      block_bits_r <= BLOCK_BITS_RST;
      ways_r       <= WAYS_RST;
      rep_r        <= 1'b0;
      b_vld_r      <= 1'b0;
      fwd_vld_r    <= 1'b0;
      row_init_r   <= '0;
      out_valid    <= 1'b0;
      hit_cnt_r    <= '0;
      miss_cnt_r   <= '0;
      evict_cnt_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SET_BITS:   set_bits_r   <= cfg_wdata[SB_W-1:0];
          CFG_BLOCK_BITS: block_bits_r <= cfg_wdata[BB_W-1:0];
          CFG_WAYS:       ways_r       <= cfg_wdata[WAYS_W-1:0];
          default: ;
        endcase
      end
      if (rep_r) begin
        rep_r   <= 1'b0;
        b_vld_r <= 1'b1;
      end else begin
        rep_r   <= accept && (in_func == FUNC_MODIFY);
        b_vld_r <= accept && (in_func != FUNC_INSTR);
      end
      fwd_vld_r <= b_vld_r;
      out_valid <= b_vld_r;
      if (b_vld_r) begin
        row_init_r[b_set_r] <= 1'b1;
        hit_cnt_r           <= hit_cnt_nxt;
        miss_cnt_r          <= miss_cnt_nxt;
        evict_cnt_r         <= evict_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rep_r) begin
      b_last_r <= 1'b1;
    end else if (accept) begin
      b_set_r  <= in_set;
      b_tag_r  <= in_tag;
      b_last_r <= (in_func != FUNC_MODIFY);
    end
    rd_valid_r <= mem_valid[rd_addr];
    rd_tag_r   <= mem_tag[rd_addr];
    rd_rec_r   <= mem_rec[rd_addr];
    rd_init_r  <= row_init_r[rd_addr];
    if (b_vld_r) begin
      mem_valid[b_set_r] <= new_valid;
      mem_tag[b_set_r]   <= new_tag;
      mem_rec[b_set_r]   <= new_rec;
    end
    fwd_set_r        <= b_set_r;
    fwd_valid_r      <= new_valid;
    fwd_tag_r        <= new_tag;
    fwd_rec_r        <= new_rec;
    out_outcome      <= outcome;
    out_way_used     <= way_ext[WAY_OUT_W-1:0];
    out_hit_total    <= hit_cnt_nxt;
    out_miss_total   <= miss_cnt_nxt;
    out_evict_total  <= evict_cnt_nxt;
    out_last_of_item <= b_last_r;
  end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU cache tag model. A scoreboard class keeps
// its own copy of the tag, valid and recency arrays and the totals, predicts
// the outcome of every access of each accepted request, and checks each
// result strobe against the oldest prediction. Directed requests cover the
// corner cases; random phases sweep the geometry registers.
// ----------------------------------------------------------------------------
module tb_top;
  import sacl_pkg::*;

  localparam int unsigned WAYS_MAX   = 8;
  localparam int unsigned SETS_MAX   = 6;
  localparam int unsigned LINES      = (1 << SETS_MAX) * WAYS_MAX;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned SETTLE     = 6;
  localparam int unsigned PHASES     = 12;
  localparam int unsigned PHASE_REQS = 96;

  localparam int unsigned PH_SB   [PHASES] = '{1, 6, 0, 7, 3, 6, 2, 4, 5, 1, 6, 2};
  localparam int unsigned PH_BB   [PHASES] = '{1, 32, 0, 63, 5, 1, 6, 60, 10, 4, 57, 3};
  localparam int unsigned PH_WAYS [PHASES] = '{1, 8, 0, 15, 2, 8, 4, 3, 8, 5, 7, 6};

  typedef struct packed {
    logic [OUTC_W-1:0]    outcome;
    logic [WAY_OUT_W-1:0] way;
    logic [CNT_W-1:0]     hits;
    logic [CNT_W-1:0]     misses;
    logic [CNT_W-1:0]     evicts;
    logic                 last;
  } access_result_t;

  class cache_tag_scoreboard;
    bit             line_ok  [LINES];
    logic [63:0]    tag_mem  [LINES];
    int unsigned    rank     [LINES];
    logic [CNT_W-1:0]  hits;
    logic [CNT_W-1:0]  misses;
    logic [CNT_W-1:0]  evicts;
    logic [SB_W-1:0]   set_bits_r;
    logic [BB_W-1:0]   block_bits_r;
    logic [WAYS_W-1:0] ways_r;
    access_result_t    pending_results[$];
    int unsigned       err_count;

    function new();
      foreach (line_ok[i]) begin
        line_ok[i] = 1'b0;
        tag_mem[i] = '0;
        rank[i]    = 0;
      end
      hits         = '0;
      misses       = '0;
      evicts       = '0;
      set_bits_r   = SET_BITS_RST;
      block_bits_r = BLOCK_BITS_RST;
      ways_r       = WAYS_RST;
      err_count    = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        CFG_SET_BITS:   set_bits_r   = data[SB_W-1:0];
        CFG_BLOCK_BITS: block_bits_r = data[BB_W-1:0];
        CFG_WAYS:       ways_r       = data[WAYS_W-1:0];
        default: ;
      endcase
    endfunction

    function void geometry(output int unsigned sbe, output int unsigned bbe,
                           output int unsigned we);
      sbe = set_bits_r;
      bbe = block_bits_r;
      we  = ways_r;
      if (sbe < 1) sbe = 1;
      if (sbe > SETS_MAX) sbe = SETS_MAX;
      if (bbe < 1) bbe = 1;
      if (we < 1) we = 1;
      if (we > WAYS_MAX) we = WAYS_MAX;
    endfunction

    // age every valid line younger than the touched one, then make it newest
    function void promote(int unsigned base, int unsigned w, int unsigned old);
      for (int unsigned i = 0; i < WAYS_MAX; i++) begin
        if (i != w && line_ok[base + i] && rank[base + i] < old) rank[base + i]++;
      end
      rank[base + w] = 0;
    endfunction

    function void lookup(logic [63:0] a, logic last);
      int unsigned    sbe, bbe, we, base, way, best, i;
      logic [63:0]    tag;
      bit             found;
      logic [OUTC_W-1:0] outc;
      access_result_t r;
      geometry(sbe, bbe, we);
      base  = int'((a >> bbe) & ((64'd1 << sbe) - 64'd1)) * WAYS_MAX;
      tag   = (sbe + bbe >= 64) ? 64'd0 : (a >> (sbe + bbe));
      found = 1'b0;
      way   = 0;
      for (i = 0; i < we && !found; i++) begin
        if (line_ok[base + i] && tag_mem[base + i] == tag) begin
          way   = i;
          found = 1'b1;
        end
      end
      if (found) begin
        outc = OUTC_HIT;
        if (hits != '1) hits++;
        promote(base, way, rank[base + way]);
      end else begin
        if (misses != '1) misses++;
        for (i = 0; i < we && !found; i++) begin
          if (!line_ok[base + i]) begin
            way   = i;
            found = 1'b1;
          end
        end
        if (found) begin
          outc = OUTC_FILL;
          promote(base, way, WAYS_MAX);
        end else begin
          outc = OUTC_EVICT;
          if (evicts != '1) evicts++;
          best = 0;
          way  = 0;
          for (i = 0; i < we; i++) begin
            if (rank[base + i] >= best) begin
              best = rank[base + i];
              way  = i;
            end
          end
          promote(base, way, rank[base + way]);
        end
        line_ok[base + way] = 1'b1;
        tag_mem[base + way] = tag;
      end
      r.outcome = outc;
      r.way     = WAY_OUT_W'(way);
      r.hits    = hits;
      r.misses  = misses;
      r.evicts  = evicts;
      r.last    = last;
      pending_results.push_back(r);
    endfunction

    function void note_request(logic [FUNC_W-1:0] func, logic [ADDR_W-1:0] addr);
      case (func)
        FUNC_INSTR: ;
        FUNC_MODIFY: begin
          lookup(addr, 1'b0);
          lookup(addr, 1'b1);
        end
        default: lookup(addr, 1'b1);
      endcase
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      err_count++;
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    task check_result(access_result_t got);
      access_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result, outcome %0d way %0d", got.outcome, got.way));
        return;
      end
      want = pending_results.pop_front();
      compare_field("outcome",      got.outcome, want.outcome);
      compare_field("way_used",     got.way,     want.way);
      compare_field("hit_total",    got.hits,    want.hits);
      compare_field("miss_total",   got.misses,  want.misses);
      compare_field("evict_total",  got.evicts,  want.evicts);
      compare_field("last_of_item", got.last,    want.last);
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [FUNC_W-1:0]    in_func;
  logic [ADDR_W-1:0]    in_addr;
  logic                 out_valid;
  logic [OUTC_W-1:0]    out_outcome;
  logic [WAY_OUT_W-1:0] out_way_used;
  logic [CNT_W-1:0]     out_hit_total;
  logic [CNT_W-1:0]     out_miss_total;
  logic [CNT_W-1:0]     out_evict_total;
  logic                 out_last_of_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  cache_tag_scoreboard tag_board = new();

  set_assoc_cache_lru_model_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_addr          (in_addr),
    .out_valid        (out_valid),
    .out_outcome      (out_outcome),
    .out_way_used     (out_way_used),
    .out_hit_total    (out_hit_total),
    .out_miss_total   (out_miss_total),
    .out_evict_total  (out_evict_total),
    .out_last_of_item (out_last_of_item),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) tag_board.set_register(cfg_index, cfg_wdata);
      if (out_valid) begin
        tag_board.check_result({out_outcome, out_way_used, out_hit_total,
                                out_miss_total, out_evict_total, out_last_of_item});
      end
      if (start && !busy) tag_board.note_request(in_func, in_addr);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("** set_assoc_cache_lru_model_unit: FAILED **");
    $finish;
  end

  task automatic send_request(input logic [FUNC_W-1:0] func, input logic [ADDR_W-1:0] addr);
    @(negedge clk);
    start   <= 1'b1;
    in_func <= func;
    in_addr <= addr;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic hold_off(input int unsigned cycles);
    if (cycles == 0) return;
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) hold_off(0);
    else if (r < 90) hold_off($urandom_range(1, 3));
    else if (r < 98) hold_off($urandom_range(4, 10));
    else hold_off($urandom_range(20, 40));
  endtask

  // hold requests until every predicted result is back, then let the pipe settle
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (tag_board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_config(input int unsigned sbits, input int unsigned bbits,
                              input int unsigned ways);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SET_BITS;
    cfg_wdata <= {3'($urandom), 3'(sbits)};
    @(negedge clk);
    cfg_index <= CFG_BLOCK_BITS;
    cfg_wdata <= 6'(bbits);
    @(negedge clk);
    cfg_index <= CFG_WAYS;
    cfg_wdata <= {2'($urandom), 4'(ways)};
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned sbits, input int unsigned bbits,
                           input int unsigned ways, input int unsigned n, input bit gaps);
    logic [63:0]       tag_pool[10];
    int unsigned       hot_set[4];
    int unsigned       sbe, bbe, we, k, r;
    logic [63:0]       addr;
    logic [FUNC_W-1:0] func;
    write_config(sbits, bbits, ways);
    tag_board.geometry(sbe, bbe, we);
    foreach (tag_pool[i]) tag_pool[i] = {$urandom, $urandom};
    foreach (hot_set[i]) hot_set[i] = $urandom_range(0, (1 << sbe) - 1);
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      func = (r < 35) ? FUNC_LOAD : (r < 65) ? FUNC_STORE : (r < 90) ? FUNC_MODIFY : FUNC_INSTR;
      if ($urandom_range(0, 9) == 0) begin
        addr = {$urandom, $urandom};
      end else begin
        addr = (tag_pool[$urandom_range(0, we + 1)] << (sbe + bbe))
             | (64'(hot_set[$urandom_range(0, 3)]) << bbe)
             | ({$urandom, $urandom} & ((64'd1 << bbe) - 64'd1));
      end
      send_request(func, addr);
      if ($urandom_range(0, 199) == 0) drain();
      else if (gaps) random_gap();
    end
    drain();
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_func   = FUNC_LOAD;
    in_addr   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_SET_BITS;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset geometry: fill, hit, eviction, modify, ignored fetch, all-ones address
    send_request(FUNC_LOAD,   64'h0);
    send_request(FUNC_LOAD,   64'h8);
    send_request(FUNC_STORE,  64'h10);
    send_request(FUNC_MODIFY, 64'h20);
    send_request(FUNC_INSTR,  64'h0);
    send_request(FUNC_LOAD,   '1);
    send_request(FUNC_STORE,  '1);
    drain();

    // zero registers clamp to one
    write_config(0, 0, 0);
    send_request(FUNC_LOAD,   64'h0);
    send_request(FUNC_MODIFY, 64'h2);
    send_request(FUNC_LOAD,   '1);
    drain();

    // oversized registers: tag shift past the address, every tag zero
    write_config(7, 63, 15);
    send_request(FUNC_LOAD,   64'h8000_0000_0000_0000);
    send_request(FUNC_LOAD,   64'h7fff_ffff_ffff_ffff);
    send_request(FUNC_MODIFY, 64'h1234);
    drain();

    // build a duplicate tag in one set, then hit with both ways in use
    write_config(6, 4, 1);
    send_request(FUNC_LOAD, 64'h720);
    drain();
    write_config(6, 4, 2);
    send_request(FUNC_LOAD, 64'hb20);
    drain();
    write_config(6, 4, 1);
    send_request(FUNC_LOAD, 64'hb20);
    drain();
    write_config(6, 4, 2);
    send_request(FUNC_LOAD, 64'hb20);
    drain();

    for (int unsigned p = 0; p < PHASES; p++) begin
      run_phase(PH_SB[p], PH_BB[p], PH_WAYS[p], PHASE_REQS, p[0] == 1'b0);
    end

    if (tag_board.err_count == 0 && tag_board.pending() == 0) begin
      $display("** set_assoc_cache_lru_model_unit: PASSED **");
    end else begin
      $display("** set_assoc_cache_lru_model_unit: FAILED **");
    end
    $finish;
  end

endmodule
